// ===== hw/rtl/tlmt_pkg.sv =====
`timescale 1ns / 1ps
package tlmt_pkg;

    localparam int NODE_DEPTH     = 4096;
    localparam int NODE_AW        = $clog2(NODE_DEPTH);
    localparam int EDGE_DEPTH     = 8192;
    localparam int EDGE_AW        = $clog2(EDGE_DEPTH);
    localparam int EDGE_CW        = $clog2(EDGE_DEPTH + 1);
    localparam int TERM_DEPTH     = 4096;
    localparam int TERM_AW        = $clog2(TERM_DEPTH);
    localparam int BLIST_DEPTH    = 8192;
    localparam int BLIST_AW       = $clog2(BLIST_DEPTH);
    localparam int BAG_DEPTH      = 4096;
    localparam int BAG_AW         = $clog2(BAG_DEPTH);
    localparam int LETTER_DEPTH   = 16384;
    localparam int LETTER_AW      = $clog2(LETTER_DEPTH);
    localparam int MATCH_WINDOW   = 12;
    localparam int WIN_AW         = $clog2(MATCH_WINDOW);
    localparam int FILL_W         = $clog2(MATCH_WINDOW + 1);
    localparam int LPP            = 4;
    localparam int LPP_W          = $clog2(LPP + 1);
    localparam int LETTER_W       = 5;
    localparam int IDS_W          = LPP * LETTER_W;
    localparam int CP_W           = 21;

    localparam logic [15:0] NO_TERMINAL = 16'hFFFF;

    localparam logic [2:0] CMD_NODE     = 3'd0;
    localparam logic [2:0] CMD_EDGE     = 3'd1;
    localparam logic [2:0] CMD_TERMINAL = 3'd2;
    localparam logic [2:0] CMD_BLIST    = 3'd3;
    localparam logic [2:0] CMD_BAG      = 3'd4;
    localparam logic [2:0] CMD_LETTER   = 3'd5;
    localparam logic [2:0] CMD_TEXT     = 3'd6;

    typedef struct packed {
        logic [CP_W-1:0] codepoint;
        logic [15:0]     entry_link;
        logic [15:0]     entry_count;
        logic [15:0]     entry_offset;
        logic [15:0]     table_index;
        logic [2:0]      command;
    } tlmt_in_t;

    typedef struct packed {
        logic [IDS_W-1:0] letter_ids;
        logic [3:0]       match_length;
        logic [3:0]       match_offset;
        logic [2:0]       letter_count;
    } tlmt_out_t;

    typedef struct packed {
        logic     en;
        tlmt_in_t word;
    } tlmt_wr_t;

    typedef struct packed {
        logic [NODE_AW-1:0]   node;
        logic [EDGE_AW-1:0]   edge_a;
        logic [TERM_AW-1:0]   term;
        logic [BLIST_AW-1:0]  blist;
        logic [BAG_AW-1:0]    bag;
        logic [LETTER_AW-1:0] letter;
    } tlmt_rd_addr_t;

    typedef struct packed {
        logic [15:0]          node_off;
        logic [15:0]          node_cnt;
        logic [15:0]          node_term;
        logic [CP_W-1:0]      edge_key;
        logic [15:0]          edge_child;
        logic [15:0]          term_off;
        logic [15:0]          term_cnt;
        logic [15:0]          blist;
        logic [15:0]          bag_off;
        logic [15:0]          bag_cnt;
        logic [LETTER_W-1:0]  letter;
    } tlmt_rd_data_t;

endpackage

// ===== hw/rtl/tlmt_tables.sv =====
`timescale 1ns / 1ps
module tlmt_tables
    import tlmt_pkg::*;
(
    input  logic          clk,
    input  tlmt_wr_t      wr,
    input  tlmt_rd_addr_t rd_addr,
    output tlmt_rd_data_t rd_data
);

    logic [47:0]            node_mem   [0:NODE_DEPTH-1];
    logic [CP_W+15:0]       edge_mem   [0:EDGE_DEPTH-1];
    logic [31:0]            term_mem   [0:TERM_DEPTH-1];
    logic [15:0]            blist_mem  [0:BLIST_DEPTH-1];
    logic [31:0]            bag_mem    [0:BAG_DEPTH-1];
    logic [LETTER_W-1:0]    letter_mem [0:LETTER_DEPTH-1];

    logic [15:0] idx;
    assign idx = wr.word.table_index;

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.word.command == CMD_NODE && 32'(idx) < NODE_DEPTH)
        begin
            node_mem[idx[NODE_AW-1:0]] <= {wr.word.entry_offset, wr.word.entry_count,
                                           wr.word.entry_link};
        end
        if (wr.en && wr.word.command == CMD_EDGE && 32'(idx) < EDGE_DEPTH)
        begin
            edge_mem[idx[EDGE_AW-1:0]] <= {wr.word.codepoint, wr.word.entry_link};
        end
        if (wr.en && wr.word.command == CMD_TERMINAL && 32'(idx) < TERM_DEPTH)
        begin
            term_mem[idx[TERM_AW-1:0]] <= {wr.word.entry_offset, wr.word.entry_count};
        end
        if (wr.en && wr.word.command == CMD_BLIST && 32'(idx) < BLIST_DEPTH)
        begin
            blist_mem[idx[BLIST_AW-1:0]] <= wr.word.entry_link;
        end
        if (wr.en && wr.word.command == CMD_BAG && 32'(idx) < BAG_DEPTH)
        begin
            bag_mem[idx[BAG_AW-1:0]] <= {wr.word.entry_offset, wr.word.entry_count};
        end
        if (wr.en && wr.word.command == CMD_LETTER && 32'(idx) < LETTER_DEPTH)
        begin
            letter_mem[idx[LETTER_AW-1:0]] <= wr.word.entry_link[LETTER_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        {rd_data.node_off, rd_data.node_cnt, rd_data.node_term} <= node_mem[rd_addr.node];
        {rd_data.edge_key, rd_data.edge_child} <= edge_mem[rd_addr.edge_a];
        {rd_data.term_off, rd_data.term_cnt}   <= term_mem[rd_addr.term];
        rd_data.blist                          <= blist_mem[rd_addr.blist];
        {rd_data.bag_off, rd_data.bag_cnt}     <= bag_mem[rd_addr.bag];
        rd_data.letter                         <= letter_mem[rd_addr.letter];
    end

endmodule

// ===== hw/rtl/tlmt_seq.sv =====
`timescale 1ns / 1ps
module tlmt_seq
    import tlmt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [87:0]   s_tdata,
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata,
    output logic          m_tlast,
    output logic [1:0]    m_tuser,
    output tlmt_wr_t      wr,
    output tlmt_rd_addr_t rd_addr,
    input  tlmt_rd_data_t rd_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_START  = 4'd1;
    localparam logic [3:0] ST_N_RD   = 4'd2;
    localparam logic [3:0] ST_N_USE  = 4'd3;
    localparam logic [3:0] ST_SEARCH = 4'd4;
    localparam logic [3:0] ST_E_MID  = 4'd5;
    localparam logic [3:0] ST_E_END  = 4'd6;
    localparam logic [3:0] ST_EVAL   = 4'd7;
    localparam logic [3:0] ST_T_USE  = 4'd8;
    localparam logic [3:0] ST_L_LIST = 4'd9;
    localparam logic [3:0] ST_L_BI   = 4'd10;
    localparam logic [3:0] ST_L_BAG  = 4'd11;
    localparam logic [3:0] ST_L_LET  = 4'd12;
    localparam logic [3:0] ST_L_LW   = 4'd13;
    localparam logic [3:0] ST_EMIT   = 4'd14;
    localparam logic [3:0] ST_SHIFT  = 4'd15;

    tlmt_in_t in_word;
    assign in_word = tlmt_in_t'(s_tdata);

    logic [3:0]          state_reg, state_next;
    logic [CP_W-1:0]     win_reg [0:MATCH_WINDOW-1];
    logic [CP_W-1:0]     win_next [0:MATCH_WINDOW-1];
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                eos_reg, eos_next;
    logic [NODE_AW-1:0]  node_reg, node_next;
    logic [FILL_W-1:0]   p_reg, p_next;
    logic                found_reg, found_next;
    logic [TERM_AW-1:0]  best_reg, best_next;
    logic [FILL_W-1:0]   mlen_reg, mlen_next;
    logic [EDGE_CW-1:0]  lo_reg, lo_next, hi_reg, hi_next, last_reg, last_next;
    logic [FILL_W-1:0]   i_reg, i_next;
    logic [LPP_W-1:0]    j_reg, j_next;
    logic [LPP_W-1:0]    bcnt_reg, bcnt_next;
    logic [15:0]         boff_reg, boff_next;
    logic [15:0]         toff_reg, toff_next;
    logic [IDS_W-1:0]    ids_reg, ids_next;
    logic                mis_reg, mis_next;
    logic                inr_reg, inr_next;

    logic                out_valid_reg, out_valid_next;
    tlmt_out_t           out_reg, out_next;
    logic                out_last_reg, out_last_next;
    logic [1:0]          out_user_reg, out_user_next;

    logic [EDGE_CW-1:0]  mid;
    logic [16:0]         span_end;
    logic [EDGE_CW-1:0]  hi_new, lo_new;
    logic [CP_W-1:0]     cp;
    logic [16:0]         li, la;
    logic [15:0]         bi;
    logic                out_free, accept;
    logic [FILL_W-1:0]   i_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    assign wr.en   = accept;
    assign wr.word = in_word;

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign cp       = win_reg[p_reg[WIN_AW-1:0]];
    assign span_end = 17'(rd_data.node_off) + 17'(rd_data.node_cnt);
    assign hi_new   = (span_end > 17'(EDGE_DEPTH)) ? EDGE_CW'(EDGE_DEPTH)
                                                   : span_end[EDGE_CW-1:0];
    assign lo_new   = (17'(rd_data.node_off) > 17'(hi_new)) ? hi_new
                                                             : rd_data.node_off[EDGE_CW-1:0];
    assign li       = 17'(toff_reg) + 17'(i_reg);
    assign la       = 17'(boff_reg) + 17'(j_reg);
    assign bi       = inr_reg ? rd_data.blist : 16'd0;
    assign out_free = !out_valid_reg || m_tready;
    assign i_inc    = i_reg + 1'b1;

    always_comb
    begin
        rd_addr.node   = node_reg;
        rd_addr.edge_a = (state_reg == ST_SEARCH && lo_reg < hi_reg) ? mid[EDGE_AW-1:0]
                                                                     : lo_reg[EDGE_AW-1:0];
        rd_addr.term   = best_reg;
        rd_addr.blist  = li[BLIST_AW-1:0];
        rd_addr.bag    = bi[BAG_AW-1:0];
        rd_addr.letter = la[LETTER_AW-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        fill_next      = fill_reg;
        eos_next       = eos_reg;
        node_next      = node_reg;
        p_next         = p_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        mlen_next      = mlen_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        last_next      = last_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        bcnt_next      = bcnt_reg;
        boff_next      = boff_reg;
        toff_next      = toff_reg;
        ids_next       = ids_reg;
        mis_next       = mis_reg;
        inr_next       = inr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_word.command == CMD_TEXT)
                begin
                    if (fill_reg < FILL_W'(MATCH_WINDOW))
                    begin
                        win_next[fill_reg[WIN_AW-1:0]] = in_word.codepoint;
                        fill_next = fill_reg + 1'b1;
                    end
                    eos_next = s_tlast;
                    if (s_tlast || fill_reg >= FILL_W'(MATCH_WINDOW - 1))
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                node_next  = '0;
                p_next     = '0;
                found_next = 1'b0;
                mlen_next  = '0;
                mis_next   = 1'b0;
                state_next = ST_N_RD;
            end
            ST_N_RD:
            begin
                state_next = ST_N_USE;
            end
            ST_N_USE:
            begin
                if (p_reg != '0 && rd_data.node_term != NO_TERMINAL
                    && 32'(rd_data.node_term) < TERM_DEPTH)
                begin
                    best_next  = rd_data.node_term[TERM_AW-1:0];
                    mlen_next  = p_reg;
                    found_next = 1'b1;
                end
                lo_next   = lo_new;
                hi_next   = hi_new;
                last_next = hi_new;
                state_next = (p_reg < fill_reg) ? ST_SEARCH : ST_EVAL;
            end
            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = ST_E_MID;
                end
                else if (lo_reg < last_reg)
                begin
                    state_next = ST_E_END;
                end
                else
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_E_MID:
            begin
                if (rd_data.edge_key < cp)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = ST_SEARCH;
            end
            ST_E_END:
            begin
                if (rd_data.edge_key == cp && 32'(rd_data.edge_child) < NODE_DEPTH)
                begin
                    node_next  = rd_data.edge_child[NODE_AW-1:0];
                    p_next     = p_reg + 1'b1;
                    state_next = ST_N_RD;
                end
                else
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                i_next = '0;
                if (!found_reg)
                begin
                    mlen_next  = FILL_W'(1);
                    ids_next   = '0;
                    bcnt_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_T_USE;
                end
            end
            ST_T_USE:
            begin
                toff_next = rd_data.term_off;
                if (rd_data.term_cnt != 16'(mlen_reg))
                begin
                    mis_next   = 1'b1;
                    ids_next   = '0;
                    bcnt_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_L_LIST;
                end
            end
            ST_L_LIST:
            begin
                inr_next   = li < 17'(BLIST_DEPTH);
                state_next = ST_L_BI;
            end
            ST_L_BI:
            begin
                ids_next = '0;
                j_next   = '0;
                if (32'(bi) < BAG_DEPTH)
                begin
                    state_next = ST_L_BAG;
                end
                else
                begin
                    boff_next  = '0;
                    bcnt_next  = '0;
                    state_next = ST_L_LET;
                end
            end
            ST_L_BAG:
            begin
                boff_next  = rd_data.bag_off;
                bcnt_next  = (rd_data.bag_cnt > 16'(LPP)) ? LPP_W'(LPP)
                                                          : rd_data.bag_cnt[LPP_W-1:0];
                state_next = ST_L_LET;
            end
            ST_L_LET:
            begin
                if (j_reg < bcnt_reg)
                begin
                    if (la < 17'(LETTER_DEPTH))
                    begin
                        state_next = ST_L_LW;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_L_LW:
            begin
                ids_next[j_reg[LPP_W-2:0]*LETTER_W +: LETTER_W] = rd_data.letter;
                j_next     = j_reg + 1'b1;
                state_next = ST_L_LET;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.letter_count  = bcnt_reg;
                    out_next.match_offset  = found_reg ? i_reg : 4'd0;
                    out_next.match_length  = found_reg ? mlen_reg : 4'd0;
                    out_next.letter_ids    = ids_reg;
                    out_user_next[0]       = mis_reg;
                    out_user_next[1]       = eos_reg && (i_inc == fill_reg);
                    out_last_next          = (i_inc == mlen_reg)
                                             && (!eos_reg || mlen_reg == fill_reg);
                    i_next = i_inc;
                    if (i_inc == mlen_reg)
                    begin
                        state_next = ST_SHIFT;
                    end
                    else if (mis_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_L_LIST;
                    end
                end
            end
            ST_SHIFT:
            begin
                for (int k = 0; k < MATCH_WINDOW - 1; k++)
                begin
                    win_next[k] = win_reg[k + 1];
                end
                fill_next = fill_reg - 1'b1;
                mlen_next = mlen_reg - 1'b1;
                if (mlen_reg == FILL_W'(1))
                begin
                    state_next = (eos_reg && fill_reg != FILL_W'(1)) ? ST_START : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg      <= win_next;
        eos_reg      <= eos_next;
        node_reg     <= node_next;
        p_reg        <= p_next;
        found_reg    <= found_next;
        best_reg     <= best_next;
        mlen_reg     <= mlen_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        last_reg     <= last_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        bcnt_reg     <= bcnt_next;
        boff_reg     <= boff_next;
        toff_reg     <= toff_next;
        ids_reg      <= ids_next;
        mis_reg      <= mis_next;
        inr_reg      <= inr_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

endmodule

// ===== hw/rtl/trie_longest_match_transliterator.sv =====
`timescale 1ns / 1ps
// Trie longest-match transliterator.
// Input words (s_*): commands 0-5 write the node, edge, terminal, bag list,
// bag and letter tables; command 6 pushes a text codepoint, with s_tlast
// marking the last codepoint of a string.
// When the window of 12 fills, or a string ends, the block walks the trie from
// the window start. Each level reads its node entry, then binary-searches
// its edges with one edge table read per search step; each matched position
// then reads its bag list entry, bag and letters and is emitted, and the
// window then shifts past the match. s_tready is low throughout.
// Result words (m_*) leave from a single output register; a stalled
// m_tready holds the walk at its next result until the word is taken.
// Reset empties the window and the output register; table contents are
// kept and must be loaded before text is sent.
module trie_longest_match_transliterator
    import tlmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command, table_index, entry_offset, entry_count, entry_link, codepoint
    input  logic [87:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // letter_count, match_offset, match_length, letter_ids
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    // bag_mismatch, string_done
    output logic [1:0]  m_tuser
);

    tlmt_wr_t      wr;
    tlmt_rd_addr_t rd_addr;
    tlmt_rd_data_t rd_data;

    tlmt_tables u_tables (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tlmt_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .wr       (wr),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

endmodule

// ===== hw/rtl/tlmt_checker.sv =====
`timescale 1ns / 1ps
module tlmt_checker
    import tlmt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [87:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[2:0] == CMD_TEXT && s_tlast |=> !s_tready)
        else $error("ready after end of string");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("string end not last of run");

    a_mis_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[2:0] == 3'd0 && m_tdata[30:11] == '0)
        else $error("mismatch word carries letters");

endmodule

bind trie_longest_match_transliterator tlmt_checker u_tlmt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
